// ----- src/brs_pkg.sv -----
// shared types, constants and helpers for the bisection root search block
package brs_pkg;

   localparam int POINT_W    = 32;
   localparam int VALUE_W    = 32;
   localparam int POINT_FRAC = 24;
   localparam int VALUE_FRAC = 16;
   localparam int TOL_W      = 31;
   localparam int ITER_W     = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 31;
   localparam int PROD_W     = TOL_W + POINT_W;

   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL_TOL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESIDUAL_TOL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ITER_LIMIT   = 2'd2;

   localparam logic [TOL_W-1:0]  INTERVAL_TOL_RESET = 31'd1;
   localparam logic [TOL_W-1:0]  RESIDUAL_TOL_RESET = 31'd1;
   localparam logic [ITER_W-1:0] ITER_LIMIT_RESET   = 10'd100;

   localparam logic [POINT_W-1:0] POINT_ONE = 32'h0100_0000;

   typedef enum logic {
      OP_START = 1'b0,
      OP_VALUE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      KIND_EVAL    = 2'd0,
      KIND_ROOT    = 2'd1,
      KIND_INVALID = 2'd2,
      KIND_LIMIT   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_LOW  = 2'd1,
      PH_HIGH = 2'd2,
      PH_MID  = 2'd3
   } phase_type;

   function automatic logic [POINT_W-1:0] mag_point(input logic signed [POINT_W-1:0] x);
      return x[POINT_W-1] ? (~x + 1'b1) : x;
   endfunction

   function automatic logic [VALUE_W-1:0] mag_value(input logic signed [VALUE_W-1:0] x);
      return x[VALUE_W-1] ? (~x + 1'b1) : x;
   endfunction

endpackage

// ----- src/brs_req_if.sv -----
// request channel: start beats with a bracket and function value beats
interface brs_req_if;
   import brs_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       op;
   logic signed [POINT_W-1:0]  lower_bound;
   logic signed [POINT_W-1:0]  upper_bound;
   logic signed [VALUE_W-1:0]  func_value;

   modport source (output valid, output op, output lower_bound, output upper_bound,
                   output func_value, input ready);
   modport sink   (input valid, input op, input lower_bound, input upper_bound,
                   input func_value, output ready);
endinterface

// ----- src/brs_rsp_if.sv -----
// response channel: evaluate requests and search results
interface brs_rsp_if;
   import brs_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [1:0]                 kind;
   logic signed [POINT_W-1:0]  point;
   logic signed [VALUE_W-1:0]  point_value;
   logic [ITER_W-1:0]          iterations;

   modport source (output valid, output kind, output point, output point_value,
                   output iterations, input ready);
   modport sink   (input valid, input kind, input point, input point_value,
                   input iterations, output ready);
endinterface

// ----- src/bisection_root_search.sv -----
// Bisection root search sequencer driving an external function evaluator.
// A start beat (op 0) loads the bracket and the block asks for f at the lower
// end, the upper end and then each midpoint; every evaluator reply comes back
// as a value beat (op 1). Points are signed Q8.24, function values Q16.16.
// Each beat passes an input register and then a result register, and a new
// beat is taken every cycle as long as the response register is drained. The
// width and residual tolerance products are kept in registers that track the
// bracket state and the tolerances. A value beat while no search runs is
// dropped silently.
module bisection_root_search (
   input  logic                                 clock,
   input  logic                                 reset,
   brs_req_if.sink                              req_bus,
   brs_rsp_if.source                            rsp_bus,
   input  logic                                 csr_wr_en,
   input  logic [brs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [brs_pkg::CSR_DATA_W-1:0]       csr_wr_data
);
   import brs_pkg::*;

   localparam int WPAD = PROD_W - POINT_W - POINT_FRAC;
   localparam int RPAD = PROD_W - VALUE_W - VALUE_FRAC;

   // configuration
   logic [TOL_W-1:0]  tx_ff, tx_in;
   logic [TOL_W-1:0]  tf_ff, tf_in;
   logic [ITER_W-1:0] limit_ff, limit_in;

   // input stage
   logic                      in_vld_ff, in_vld_in;
   logic                      in_op_ff;
   logic signed [POINT_W-1:0] in_lo_ff, in_hi_ff;
   logic signed [VALUE_W-1:0] in_val_ff;

   // search state
   phase_type                 phase_ff, phase_in;
   logic signed [POINT_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic signed [VALUE_W-1:0] lov_ff, lov_in, hiv_ff, hiv_in;
   logic [VALUE_W-1:0]        scale_ff, scale_in;
   logic [ITER_W-1:0]         step_ff, step_in;
   logic [PROD_W-1:0]         prod_w_ff, prod_w_in, prod_r_ff, prod_r_in;

   // result stage
   logic                      rsp_vld_ff, rsp_vld_in;
   kind_type                  rsp_kind_ff, out_kind;
   logic signed [POINT_W-1:0] rsp_point_ff, out_point;
   logic signed [VALUE_W-1:0] rsp_value_ff, out_value;
   logic [ITER_W-1:0]         rsp_iter_ff, out_iter;
   logic                      out_new;

   logic                      req_fire, out_free, fire;
   logic [VALUE_W-1:0]        am, al, ah;
   logic [POINT_W:0]          mid_sum, nmid_sum, diff;
   logic signed [POINT_W-1:0] mid, nmid;
   logic [ITER_W:0]           iters;
   logic                      width_stop, res_stop, limit_hit, keep_low;
   logic                      lo_root, hi_root, same_sign, lim_zero;
   logic [POINT_W-1:0]        pscale;

   // handshake
   assign out_free      = !rsp_vld_ff || rsp_bus.ready;
   assign fire          = in_vld_ff && out_free;
   assign req_bus.ready = !in_vld_ff || out_free;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign in_vld_in     = req_fire ? 1'b1 : (fire ? 1'b0 : in_vld_ff);

   // configuration writes
   always_comb begin
      tx_in    = tx_ff;
      tf_in    = tf_ff;
      limit_in = limit_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_INTERVAL_TOL: tx_in    = csr_wr_data[TOL_W-1:0];
            CSR_RESIDUAL_TOL: tf_in    = csr_wr_data[TOL_W-1:0];
            CSR_ITER_LIMIT:   limit_in = csr_wr_data[ITER_W-1:0];
            default: ;
         endcase
      end
   end

   // decision terms
   assign am        = mag_value(in_val_ff);
   assign al        = mag_value(lov_ff);
   assign ah        = mag_value(hiv_ff);
   assign mid_sum   = {lo_ff[POINT_W-1], lo_ff} + {hi_ff[POINT_W-1], hi_ff};
   assign mid       = mid_sum[POINT_W:1];
   assign diff      = {hi_ff[POINT_W-1], hi_ff} - {lo_ff[POINT_W-1], lo_ff};
   assign width_stop = diff[POINT_W] ||
                       ({{WPAD{1'b0}}, diff[POINT_W-1:0], {POINT_FRAC{1'b0}}} < prod_w_ff);
   assign res_stop  = (tf_ff != '0) &&
                      ((am < {1'b0, tf_ff}) ||
                       ({{RPAD{1'b0}}, am, {VALUE_FRAC{1'b0}}} < prod_r_ff));
   assign iters     = {1'b0, step_ff} + 1'b1;
   assign limit_hit = iters >= {1'b0, limit_ff};
   assign keep_low  = in_val_ff[VALUE_W-1] == lov_ff[VALUE_W-1];
   assign lo_root   = al < {1'b0, tf_ff};
   assign hi_root   = am < {1'b0, tf_ff};
   assign same_sign = lov_ff[VALUE_W-1] == in_val_ff[VALUE_W-1];
   assign lim_zero  = limit_ff == '0;

   // phase sequencing
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         if (in_op_ff == OP_START) begin
            phase_in = PH_LOW;
         end else begin
            unique case (phase_ff)
               PH_IDLE: phase_in = PH_IDLE;
               PH_LOW:  phase_in = PH_HIGH;
               PH_HIGH: phase_in = (lo_root || hi_root || same_sign || lim_zero) ?
                                   PH_IDLE : PH_MID;
               PH_MID:  phase_in = (width_stop || res_stop || limit_hit) ?
                                   PH_IDLE : PH_MID;
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   // bracket update and response
   always_comb begin
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      lov_in    = lov_ff;
      hiv_in    = hiv_ff;
      scale_in  = scale_ff;
      step_in   = step_ff;
      out_new   = 1'b0;
      out_kind  = KIND_EVAL;
      out_point = '0;
      out_value = '0;
      out_iter  = '0;
      if (fire) begin
         if (in_op_ff == OP_START) begin
            lo_in     = in_lo_ff;
            hi_in     = in_hi_ff;
            lov_in    = '0;
            hiv_in    = '0;
            scale_in  = '0;
            step_in   = '0;
            out_new   = 1'b1;
            out_point = in_lo_ff;
         end else begin
            unique case (phase_ff)
               PH_IDLE: ;
               PH_LOW: begin
                  lov_in    = in_val_ff;
                  out_new   = 1'b1;
                  out_point = hi_ff;
               end
               PH_HIGH: begin
                  hiv_in  = in_val_ff;
                  out_new = 1'b1;
                  if (lo_root) begin
                     out_kind  = KIND_ROOT;
                     out_point = lo_ff;
                     out_value = lov_ff;
                  end else if (hi_root) begin
                     out_kind  = KIND_ROOT;
                     out_point = hi_ff;
                     out_value = in_val_ff;
                  end else if (same_sign) begin
                     out_kind = KIND_INVALID;
                  end else begin
                     scale_in = (al > am) ? al : am;
                     if (lim_zero) begin
                        out_kind = KIND_LIMIT;
                     end else begin
                        out_point = mid;
                     end
                  end
               end
               PH_MID: begin
                  out_new = 1'b1;
                  if (width_stop || res_stop) begin
                     out_kind  = KIND_ROOT;
                     out_point = mid;
                     out_value = in_val_ff;
                     out_iter  = iters[ITER_W-1:0];
                  end else begin
                     if (keep_low) begin
                        lo_in    = mid;
                        lov_in   = in_val_ff;
                        scale_in = (am > ah) ? am : ah;
                     end else begin
                        hi_in    = mid;
                        hiv_in   = in_val_ff;
                        scale_in = (al > am) ? al : am;
                     end
                     step_in = iters[ITER_W-1:0];
                     if (limit_hit) begin
                        out_kind = KIND_LIMIT;
                     end else begin
                        out_point = nmid;
                     end
                  end
               end
               default: ;
            endcase
         end
      end
   end

   assign nmid_sum = keep_low ? ({mid[POINT_W-1], mid} + {hi_ff[POINT_W-1], hi_ff})
                              : ({lo_ff[POINT_W-1], lo_ff} + {mid[POINT_W-1], mid});
   assign nmid     = nmid_sum[POINT_W:1];

   // tolerance products follow the next bracket and tolerances
   assign pscale    = (mag_point(lo_in) > mag_point(hi_in)) ? mag_point(lo_in)
                                                            : mag_point(hi_in);
   assign prod_w_in = PROD_W'(tx_in) * PROD_W'(POINT_ONE + pscale);
   assign prod_r_in = PROD_W'(tf_in) * PROD_W'(scale_in);

   assign rsp_vld_in = fire ? out_new : (rsp_bus.ready ? 1'b0 : rsp_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_ff      <= INTERVAL_TOL_RESET;
         tf_ff      <= RESIDUAL_TOL_RESET;
         limit_ff   <= ITER_LIMIT_RESET;
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         phase_ff   <= PH_IDLE;
         lo_ff      <= '0;
         hi_ff      <= '0;
         lov_ff     <= '0;
         hiv_ff     <= '0;
         scale_ff   <= '0;
         step_ff    <= '0;
         prod_w_ff  <= PROD_W'(POINT_ONE);
         prod_r_ff  <= '0;
      end else begin
         tx_ff      <= tx_in;
         tf_ff      <= tf_in;
         limit_ff   <= limit_in;
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         phase_ff   <= phase_in;
         lo_ff      <= lo_in;
         hi_ff      <= hi_in;
         lov_ff     <= lov_in;
         hiv_ff     <= hiv_in;
         scale_ff   <= scale_in;
         step_ff    <= step_in;
         prod_w_ff  <= prod_w_in;
         prod_r_ff  <= prod_r_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_op_ff  <= req_bus.op;
         in_lo_ff  <= req_bus.lower_bound;
         in_hi_ff  <= req_bus.upper_bound;
         in_val_ff <= req_bus.func_value;
      end
      if (fire && out_new) begin
         rsp_kind_ff  <= out_kind;
         rsp_point_ff <= out_point;
         rsp_value_ff <= out_value;
         rsp_iter_ff  <= out_iter;
      end
   end

   assign rsp_bus.valid       = rsp_vld_ff;
   assign rsp_bus.kind        = rsp_kind_ff;
   assign rsp_bus.point       = rsp_point_ff;
   assign rsp_bus.point_value = rsp_value_ff;
   assign rsp_bus.iterations  = rsp_iter_ff;

endmodule
